FILE: hw/rtl/tdsp_pkg.sv
// table database stream parser: shared types and constants
// parse phases, result kinds, error codes, the result record and the magic text
// no dependencies
package tdsp_pkg;

  // header layout
  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned MAGIC_BYTES     = 12;
  localparam logic [31:0] MIN_FILE_LENGTH = 32'd24;

  // register reset values
  localparam logic [16:0] MAX_TABLE_RESET = 17'd100000;
  localparam logic [26:0] MAX_CELL_RESET  = 27'd100000000;

  // configuration register indexes
  localparam logic [1:0] REG_FILE_LENGTH = 2'd0;
  localparam logic [1:0] REG_MAX_TABLES  = 2'd1;
  localparam logic [1:0] REG_MAX_CELLS   = 2'd2;

  localparam logic [7:0] MAGIC_TEXT [MAGIC_BYTES] = '{
    8'h54, 8'h41, 8'h42, 8'h4C, 8'h45, 8'h20,
    8'h44, 8'h41, 8'h54, 8'h41, 8'h20, 8'h56
  };

  typedef enum logic [3:0] {
    PH_MAGIC, PH_SKIP, PH_FLAG, PH_SIZE, PH_COUNT, PH_NUMBER,
    PH_ROWS, PH_COLS, PH_NUMERIC, PH_STRLEN, PH_STRCHAR, PH_END
  } phase_t;

  typedef enum logic [3:0] {
    KIND_NUMBER, KIND_ROWS, KIND_COLS, KIND_NUMERIC, KIND_STRLEN,
    KIND_CHAR, KIND_COUNT, KIND_DONE, KIND_ERROR
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE, ERR_MAGIC, ERR_TRUNCATED, ERR_COMPRESSED, ERR_COUNT,
    ERR_HEADER, ERR_CELLS, ERR_NUMERIC, ERR_STRING, ERR_TRAILING
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [16:0] table_position;
    logic [26:0] cell_position;
    err_t        error_code;
    logic        last;
  } result_t;

endpackage

FILE: hw/rtl/table_database_stream_parser.sv
// table database stream parser, top level
// byte-wise parse logic feeding a four-entry result queue
// depends on tdsp_pkg
//
// Accepts one file byte per cycle and returns the parsed items (table count,
// per table its number, rows and columns, numeric cells, string lengths and
// inverted string characters, then done or an error). Each byte goes through
// one combinational pass into the parse registers and a four-entry result
// queue; a byte yields at most two results, so in_ready drops only when the
// queue holds more than two results, and with a draining consumer the block
// takes one byte every cycle. The rows by columns product is accumulated
// byte by byte while the column word arrives, one 27x8 multiply per byte.
// After done or an error every further byte is taken and dropped. Load
// file_length before the first byte.
module table_database_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        config_write,
  input  logic [1:0]  config_index,
  input  logic [31:0] config_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [31:0] value,
  output logic [16:0] table_position,
  output logic [26:0] cell_position,
  output logic [3:0]  error_code,
  output logic        last
);

  localparam int unsigned DEPTH = 4;

  // configuration registers
  logic [31:0] file_length;
  logic [16:0] max_table_count;
  logic [26:0] max_cell_count;

  // parse state
  tdsp_pkg::phase_t parse_phase, parse_phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] word_assembler, word_assembler_next;
  logic [1:0]  byte_in_word, byte_in_word_next;
  logic [31:0] payload_left, payload_left_next;
  logic [16:0] tables_left, tables_left_next;
  logic [30:0] row_count_held, row_count_held_next;
  logic [26:0] cells_left, cells_left_next;
  logic [31:0] string_bytes_left, string_bytes_left_next;
  logic [16:0] table_counter, table_counter_next;
  logic [26:0] cell_counter, cell_counter_next;
  logic        failed, failed_next;
  logic [26:0] product, product_next;
  logic        product_big, product_big_next;

  // result queue
  tdsp_pkg::result_t queue [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  tdsp_pkg::result_t res0, res1;
  logic [1:0] n_push;
  logic       accept, pop;

  assign in_ready = (fill < 3'd3);
  assign accept   = in_valid && in_ready;
  assign out_valid = (fill != 3'd0);
  assign pop      = out_valid && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length     <= '0;
      max_table_count <= tdsp_pkg::MAX_TABLE_RESET;
      max_cell_count  <= tdsp_pkg::MAX_CELL_RESET;
    end else if (config_write) begin
      case (config_index)
        tdsp_pkg::REG_FILE_LENGTH: file_length     <= config_data;
        tdsp_pkg::REG_MAX_TABLES:  max_table_count <= config_data[16:0];
        tdsp_pkg::REG_MAX_CELLS:   max_cell_count  <= config_data[26:0];
        default: ;
      endcase
    end
  end

  // one byte through the parser
  always_comb begin
    tdsp_pkg::result_t r [2];
    logic [1:0]  n;
    logic [31:0] pl, w, avail;
    logic [34:0] term;
    logic [59:0] sum;
    logic        do_fail, do_next_string, do_end_table, do_begin_table, word_full;
    tdsp_pkg::err_t code;

    r[0] = '0;
    r[1] = '0;
    n = '0;
    pl = payload_left;
    w = '0;
    avail = '0;
    term = '0;
    sum = '0;
    do_fail = 1'b0;
    do_next_string = 1'b0;
    do_end_table = 1'b0;
    do_begin_table = 1'b0;
    word_full = 1'b0;
    code = tdsp_pkg::ERR_NONE;

    parse_phase_next       = parse_phase;
    byte_position_next     = byte_position;
    word_assembler_next    = word_assembler;
    byte_in_word_next      = byte_in_word;
    tables_left_next       = tables_left;
    row_count_held_next    = row_count_held;
    cells_left_next        = cells_left;
    string_bytes_left_next = string_bytes_left;
    table_counter_next     = table_counter;
    cell_counter_next      = cell_counter;
    failed_next            = failed;
    product_next           = product;
    product_big_next       = product_big;

    if (accept && parse_phase != tdsp_pkg::PH_END) begin
      byte_position_next = byte_position + 4'd1;
      if (parse_phase >= tdsp_pkg::PH_COUNT && pl != '0) begin
        pl = pl - 32'd1;
      end

      case (parse_phase)
        tdsp_pkg::PH_MAGIC: begin
          if ((byte_position == '0 && file_length < tdsp_pkg::MIN_FILE_LENGTH) ||
              data_byte != tdsp_pkg::MAGIC_TEXT[byte_position]) begin
            do_fail = 1'b1;
            code = tdsp_pkg::ERR_MAGIC;
          end else if (byte_position == 4'(tdsp_pkg::MAGIC_BYTES - 1)) begin
            parse_phase_next = tdsp_pkg::PH_SKIP;
          end
        end
        tdsp_pkg::PH_SKIP: begin
          if (byte_position == 4'(tdsp_pkg::HEADER_BYTES - 1)) begin
            parse_phase_next = tdsp_pkg::PH_FLAG;
            word_assembler_next = '0;
            byte_in_word_next = '0;
          end
        end
        tdsp_pkg::PH_STRCHAR: begin
          r[n[0]] = '{tdsp_pkg::KIND_CHAR, {24'd0, ~data_byte}, table_counter,
                      cell_counter, tdsp_pkg::ERR_NONE, 1'b0};
          n = n + 2'd1;
          string_bytes_left_next = string_bytes_left - 32'd1;
          if (string_bytes_left_next == '0) do_next_string = 1'b1;
        end
        default: begin
          // little-endian word assembly
          w = word_assembler | ({24'd0, data_byte} << {byte_in_word, 3'b000});
          // running rows by columns product while the column word arrives
          if (parse_phase == tdsp_pkg::PH_COLS) begin
            term = row_count_held[26:0] * data_byte;
            sum = {33'd0, product} + ({25'd0, term} << {byte_in_word, 3'b000});
            product_next = sum[26:0];
            product_big_next = product_big || (sum[59:27] != '0) ||
                               (row_count_held[30:27] != '0 && data_byte != '0);
          end
          if (byte_in_word != 2'd3) begin
            word_assembler_next = w;
            byte_in_word_next = byte_in_word + 2'd1;
          end else begin
            word_assembler_next = '0;
            byte_in_word_next = '0;
            word_full = 1'b1;
          end
        end
      endcase

      // complete word
      if (word_full) begin
        case (parse_phase)
          tdsp_pkg::PH_FLAG: begin
            if (w != '0) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_COMPRESSED;
            end else begin
              parse_phase_next = tdsp_pkg::PH_SIZE;
            end
          end
          tdsp_pkg::PH_SIZE: begin
            avail = (file_length >= tdsp_pkg::MIN_FILE_LENGTH) ?
                    file_length - tdsp_pkg::MIN_FILE_LENGTH : '0;
            if (w > avail) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_TRUNCATED;
            end else begin
              pl = w;
              if (pl < 32'd4) begin
                do_fail = 1'b1;
                code = tdsp_pkg::ERR_COUNT;
              end else begin
                parse_phase_next = tdsp_pkg::PH_COUNT;
              end
            end
          end
          tdsp_pkg::PH_COUNT: begin
            if (w[31] || w > {15'd0, max_table_count}) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_COUNT;
            end else begin
              r[n[0]] = '{tdsp_pkg::KIND_COUNT, w, 17'd0, 27'd0, tdsp_pkg::ERR_NONE, 1'b0};
              n = n + 2'd1;
              tables_left_next = w[16:0];
              table_counter_next = '0;
              do_begin_table = 1'b1;
            end
          end
          tdsp_pkg::PH_NUMBER: begin
            r[n[0]] = '{tdsp_pkg::KIND_NUMBER, w, table_counter, 27'd0,
                        tdsp_pkg::ERR_NONE, 1'b0};
            n = n + 2'd1;
            if (pl < 32'd4) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_HEADER;
            end else begin
              parse_phase_next = tdsp_pkg::PH_ROWS;
            end
          end
          tdsp_pkg::PH_ROWS: begin
            if (w[31]) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_HEADER;
            end else begin
              row_count_held_next = w[30:0];
              product_next = '0;
              product_big_next = 1'b0;
              r[n[0]] = '{tdsp_pkg::KIND_ROWS, w, table_counter, 27'd0,
                          tdsp_pkg::ERR_NONE, 1'b0};
              n = n + 2'd1;
              if (pl < 32'd4) begin
                do_fail = 1'b1;
                code = tdsp_pkg::ERR_HEADER;
              end else begin
                parse_phase_next = tdsp_pkg::PH_COLS;
              end
            end
          end
          tdsp_pkg::PH_COLS: begin
            if (w[31]) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_HEADER;
            end else if (product_big_next || product_next > max_cell_count ||
                         {3'd0, product_next} > pl[31:2]) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_CELLS;
            end else begin
              r[n[0]] = '{tdsp_pkg::KIND_COLS, w, table_counter, 27'd0,
                          tdsp_pkg::ERR_NONE, 1'b0};
              n = n + 2'd1;
              cell_counter_next = '0;
              cells_left_next = product_next;
              if (product_next == '0) begin
                do_end_table = 1'b1;
              end else begin
                parse_phase_next = tdsp_pkg::PH_NUMERIC;
              end
            end
          end
          tdsp_pkg::PH_NUMERIC: begin
            r[n[0]] = '{tdsp_pkg::KIND_NUMERIC, w, table_counter, cell_counter,
                        tdsp_pkg::ERR_NONE, 1'b0};
            n = n + 2'd1;
            cell_counter_next = cell_counter + 27'd1;
            cells_left_next = cells_left - 27'd1;
            if (cells_left_next == '0) begin
              cells_left_next = cell_counter_next;
              cell_counter_next = '0;
              if (pl < 32'd4) begin
                do_fail = 1'b1;
                code = tdsp_pkg::ERR_STRING;
              end else begin
                parse_phase_next = tdsp_pkg::PH_STRLEN;
              end
            end
          end
          tdsp_pkg::PH_STRLEN: begin
            if (w > pl) begin
              do_fail = 1'b1;
              code = tdsp_pkg::ERR_STRING;
            end else begin
              r[n[0]] = '{tdsp_pkg::KIND_STRLEN, w, table_counter, cell_counter,
                          tdsp_pkg::ERR_NONE, 1'b0};
              n = n + 2'd1;
              if (w == '0) begin
                do_next_string = 1'b1;
              end else begin
                string_bytes_left_next = w;
                parse_phase_next = tdsp_pkg::PH_STRCHAR;
              end
            end
          end
          default: parse_phase_next = tdsp_pkg::PH_END;
        endcase
      end

      // advance to the next string
      if (do_next_string) begin
        cell_counter_next = cell_counter_next + 27'd1;
        cells_left_next = cells_left_next - 27'd1;
        if (cells_left_next == '0) begin
          do_end_table = 1'b1;
        end else if (pl < 32'd4) begin
          do_fail = 1'b1;
          code = tdsp_pkg::ERR_STRING;
        end else begin
          parse_phase_next = tdsp_pkg::PH_STRLEN;
        end
      end

      // close the table
      if (do_end_table) begin
        tables_left_next = tables_left_next - 17'd1;
        table_counter_next = table_counter_next + 17'd1;
        cell_counter_next = '0;
        do_begin_table = 1'b1;
      end

      // open the next table or finish
      if (do_begin_table) begin
        if (tables_left_next == '0) begin
          parse_phase_next = tdsp_pkg::PH_END;
          if (pl != '0) begin
            do_fail = 1'b1;
            code = tdsp_pkg::ERR_TRAILING;
          end else begin
            r[n[0]] = '{tdsp_pkg::KIND_DONE, 32'd0, table_counter_next, 27'd0,
                        tdsp_pkg::ERR_NONE, 1'b1};
            n = n + 2'd1;
          end
        end else begin
          cell_counter_next = '0;
          if (pl < 32'd4) begin
            do_fail = 1'b1;
            code = tdsp_pkg::ERR_HEADER;
          end else begin
            parse_phase_next = tdsp_pkg::PH_NUMBER;
          end
        end
      end

      // error ends the parse
      if (do_fail) begin
        failed_next = 1'b1;
        parse_phase_next = tdsp_pkg::PH_END;
        r[n[0]] = '{tdsp_pkg::KIND_ERROR, 32'd0, table_counter_next, cell_counter_next,
                    code, 1'b1};
        n = n + 2'd1;
      end
    end

    payload_left_next = pl;
    res0 = r[0];
    res1 = r[1];
    n_push = n;
  end

  // parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= tdsp_pkg::PH_MAGIC;
      byte_position     <= '0;
      word_assembler    <= '0;
      byte_in_word      <= '0;
      payload_left      <= '0;
      tables_left       <= '0;
      row_count_held    <= '0;
      cells_left        <= '0;
      string_bytes_left <= '0;
      table_counter     <= '0;
      cell_counter      <= '0;
      failed            <= 1'b0;
      product           <= '0;
      product_big       <= 1'b0;
    end else begin
      parse_phase       <= parse_phase_next;
      byte_position     <= byte_position_next;
      word_assembler    <= word_assembler_next;
      byte_in_word      <= byte_in_word_next;
      payload_left      <= payload_left_next;
      tables_left       <= tables_left_next;
      row_count_held    <= row_count_held_next;
      cells_left        <= cells_left_next;
      string_bytes_left <= string_bytes_left_next;
      table_counter     <= table_counter_next;
      cell_counter      <= cell_counter_next;
      failed            <= failed_next;
      product           <= product_next;
      product_big       <= product_big_next;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (n_push != '0) queue[wr_ptr] <= res0;
    if (n_push == 2'd2) queue[wr_ptr + 2'd1] <= res1;
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {1'b0, n_push} - {2'd0, pop};
    end
  end

  // output fields
  assign kind           = queue[rd_ptr].kind;
  assign value          = queue[rd_ptr].value;
  assign table_position = queue[rd_ptr].table_position;
  assign cell_position  = queue[rd_ptr].cell_position;
  assign error_code     = queue[rd_ptr].error_code;
  assign last           = queue[rd_ptr].last;

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) fill <= 3'(DEPTH))
    else $error("result queue overfilled");

  // nothing is produced once the parse has ended
  assert property (@(posedge clk) disable iff (rst)
    parse_phase == tdsp_pkg::PH_END |-> n_push == '0)
    else $error("result after end of parse");

  // a final result always leaves the parser ended
  assert property (@(posedge clk) disable iff (rst)
    (n_push != '0 && ((n_push == 2'd1 && res0.last) || (n_push == 2'd2 && res1.last)))
    |=> parse_phase == tdsp_pkg::PH_END)
    else $error("final result without end of parse");

  // an error result implies the failed flag follows
  assert property (@(posedge clk) disable iff (rst)
    (n_push != '0 && (res0.kind == tdsp_pkg::KIND_ERROR ||
                      (n_push == 2'd2 && res1.kind == tdsp_pkg::KIND_ERROR)))
    |=> failed)
    else $error("error result without failed flag");

endmodule

FILE: dv/tdsp_checker.sv
// result checker for the table database stream parser
// watches the config port and both channels, predicts each result and compares
// depends on tdsp_pkg
module tdsp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        config_write,
  input  logic [1:0]  config_index,
  input  logic [31:0] config_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  kind,
  input  logic [31:0] value,
  input  logic [16:0] table_position,
  input  logic [26:0] cell_position,
  input  logic [3:0]  error_code,
  input  logic        last,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // configuration copy
  logic [31:0] file_len;
  logic [16:0] table_limit;
  logic [26:0] cell_limit;

  // parse state
  logic [31:0]      byte_count;
  tdsp_pkg::phase_t phase;
  logic [31:0]      word_acc;
  logic [1:0]       word_byte;
  logic [31:0]      payload_left;
  logic [16:0]      tables_left;
  logic [30:0]      rows_held;
  logic [26:0]      cells_left;
  logic [31:0]      chars_left;
  logic [16:0]      table_idx;
  logic [26:0]      cell_idx;

  tdsp_pkg::result_t expected_results[$];
  int                bad_count;

  task automatic post(tdsp_pkg::kind_t k, logic [31:0] v, logic [16:0] tp,
                      logic [26:0] cp, tdsp_pkg::err_t e, logic l);
    tdsp_pkg::result_t r;
    r.kind = k;
    r.value = v;
    r.table_position = tp;
    r.cell_position = cp;
    r.error_code = e;
    r.last = l;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic raise_error(tdsp_pkg::err_t e);
    phase = tdsp_pkg::PH_END;
    post(tdsp_pkg::KIND_ERROR, 32'd0, table_idx, cell_idx, e, 1'b1);
  endtask

  // start the next table, or finish when none are left
  task automatic open_table();
    if (tables_left == 17'd0) begin
      phase = tdsp_pkg::PH_END;
      if (payload_left != 32'd0) raise_error(tdsp_pkg::ERR_TRAILING);
      else post(tdsp_pkg::KIND_DONE, 32'd0, table_idx, 27'd0, tdsp_pkg::ERR_NONE, 1'b1);
      return;
    end
    cell_idx = 27'd0;
    if (payload_left < 32'd4) raise_error(tdsp_pkg::ERR_HEADER);
    else phase = tdsp_pkg::PH_NUMBER;
  endtask

  task automatic close_table();
    tables_left = tables_left - 17'd1;
    table_idx = table_idx + 17'd1;
    cell_idx = 27'd0;
    open_table();
  endtask

  task automatic advance_string();
    cell_idx = cell_idx + 27'd1;
    cells_left = cells_left - 27'd1;
    if (cells_left == 27'd0) close_table();
    else if (payload_left < 32'd4) raise_error(tdsp_pkg::ERR_STRING);
    else phase = tdsp_pkg::PH_STRLEN;
  endtask

  // act on a completed little-endian word
  task automatic finish_word(logic [31:0] w);
    logic [63:0] cells;
    logic [31:0] avail;
    case (phase)
      tdsp_pkg::PH_FLAG: begin
        if (w != 32'd0) raise_error(tdsp_pkg::ERR_COMPRESSED);
        else phase = tdsp_pkg::PH_SIZE;
      end
      tdsp_pkg::PH_SIZE: begin
        avail = (file_len >= tdsp_pkg::MIN_FILE_LENGTH) ?
                file_len - tdsp_pkg::MIN_FILE_LENGTH : 32'd0;
        if (w > avail) raise_error(tdsp_pkg::ERR_TRUNCATED);
        else begin
          payload_left = w;
          if (payload_left < 32'd4) raise_error(tdsp_pkg::ERR_COUNT);
          else phase = tdsp_pkg::PH_COUNT;
        end
      end
      tdsp_pkg::PH_COUNT: begin
        if (w[31] || w > {15'd0, table_limit}) raise_error(tdsp_pkg::ERR_COUNT);
        else begin
          post(tdsp_pkg::KIND_COUNT, w, 17'd0, 27'd0, tdsp_pkg::ERR_NONE, 1'b0);
          tables_left = w[16:0];
          table_idx = 17'd0;
          open_table();
        end
      end
      tdsp_pkg::PH_NUMBER: begin
        post(tdsp_pkg::KIND_NUMBER, w, table_idx, 27'd0, tdsp_pkg::ERR_NONE, 1'b0);
        if (payload_left < 32'd4) raise_error(tdsp_pkg::ERR_HEADER);
        else phase = tdsp_pkg::PH_ROWS;
      end
      tdsp_pkg::PH_ROWS: begin
        if (w[31]) raise_error(tdsp_pkg::ERR_HEADER);
        else begin
          rows_held = w[30:0];
          post(tdsp_pkg::KIND_ROWS, w, table_idx, 27'd0, tdsp_pkg::ERR_NONE, 1'b0);
          if (payload_left < 32'd4) raise_error(tdsp_pkg::ERR_HEADER);
          else phase = tdsp_pkg::PH_COLS;
        end
      end
      tdsp_pkg::PH_COLS: begin
        cells = {33'd0, rows_held} * {32'd0, w};
        if (w[31]) raise_error(tdsp_pkg::ERR_HEADER);
        else if (cells > {37'd0, cell_limit} || cells > {34'd0, payload_left[31:2]})
          raise_error(tdsp_pkg::ERR_CELLS);
        else begin
          post(tdsp_pkg::KIND_COLS, w, table_idx, 27'd0, tdsp_pkg::ERR_NONE, 1'b0);
          cell_idx = 27'd0;
          cells_left = cells[26:0];
          if (cells_left == 27'd0) close_table();
          else phase = tdsp_pkg::PH_NUMERIC;
        end
      end
      tdsp_pkg::PH_NUMERIC: begin
        post(tdsp_pkg::KIND_NUMERIC, w, table_idx, cell_idx, tdsp_pkg::ERR_NONE, 1'b0);
        cell_idx = cell_idx + 27'd1;
        cells_left = cells_left - 27'd1;
        if (cells_left == 27'd0) begin
          cells_left = cell_idx;
          cell_idx = 27'd0;
          if (payload_left < 32'd4) raise_error(tdsp_pkg::ERR_STRING);
          else phase = tdsp_pkg::PH_STRLEN;
        end
      end
      tdsp_pkg::PH_STRLEN: begin
        if (w > payload_left) raise_error(tdsp_pkg::ERR_STRING);
        else begin
          post(tdsp_pkg::KIND_STRLEN, w, table_idx, cell_idx, tdsp_pkg::ERR_NONE, 1'b0);
          if (w == 32'd0) advance_string();
          else begin
            chars_left = w;
            phase = tdsp_pkg::PH_STRCHAR;
          end
        end
      end
      default: phase = tdsp_pkg::PH_END;
    endcase
  endtask

  // one accepted file byte
  task automatic parse_byte(logic [7:0] b);
    logic [31:0] pos;
    logic [31:0] w;
    if (phase == tdsp_pkg::PH_END) return;
    pos = byte_count;
    byte_count = byte_count + 32'd1;
    if (phase >= tdsp_pkg::PH_COUNT && payload_left != 32'd0)
      payload_left = payload_left - 32'd1;
    case (phase)
      tdsp_pkg::PH_MAGIC: begin
        if (pos == 32'd0 && file_len < tdsp_pkg::MIN_FILE_LENGTH)
          raise_error(tdsp_pkg::ERR_MAGIC);
        else if (pos >= tdsp_pkg::MAGIC_BYTES || b != tdsp_pkg::MAGIC_TEXT[pos[3:0]])
          raise_error(tdsp_pkg::ERR_MAGIC);
        else if (pos == tdsp_pkg::MAGIC_BYTES - 1) phase = tdsp_pkg::PH_SKIP;
      end
      tdsp_pkg::PH_SKIP: begin
        if (pos + 32'd1 >= tdsp_pkg::HEADER_BYTES) begin
          phase = tdsp_pkg::PH_FLAG;
          word_acc = 32'd0;
          word_byte = 2'd0;
        end
      end
      tdsp_pkg::PH_STRCHAR: begin
        post(tdsp_pkg::KIND_CHAR, {24'd0, ~b}, table_idx, cell_idx, tdsp_pkg::ERR_NONE,
             1'b0);
        chars_left = chars_left - 32'd1;
        if (chars_left == 32'd0) advance_string();
      end
      default: begin
        word_acc = word_acc | ({24'd0, b} << (8 * word_byte));
        if (word_byte < 2'd3) word_byte = word_byte + 2'd1;
        else begin
          w = word_acc;
          word_acc = 32'd0;
          word_byte = 2'd0;
          finish_word(w);
        end
      end
    endcase
  endtask

  // track config, predict, compare
  always @(posedge clk) begin
    tdsp_pkg::result_t exp_r;
    if (rst) begin
      file_len = 32'd0;
      table_limit = tdsp_pkg::MAX_TABLE_RESET;
      cell_limit = tdsp_pkg::MAX_CELL_RESET;
      byte_count = 32'd0;
      phase = tdsp_pkg::PH_MAGIC;
      word_acc = 32'd0;
      word_byte = 2'd0;
      payload_left = 32'd0;
      tables_left = 17'd0;
      rows_held = 31'd0;
      cells_left = 27'd0;
      chars_left = 32'd0;
      table_idx = 17'd0;
      cell_idx = 27'd0;
      bad_count = 0;
      expected_results.delete();
    end else begin
      if (config_write) begin
        case (config_index)
          tdsp_pkg::REG_FILE_LENGTH: file_len = config_data;
          tdsp_pkg::REG_MAX_TABLES:  table_limit = config_data[16:0];
          tdsp_pkg::REG_MAX_CELLS:   cell_limit = config_data[26:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected result: kind %0d value %h", kind, value);
          bad_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (kind !== exp_r.kind || value !== exp_r.value ||
              table_position !== exp_r.table_position ||
              cell_position !== exp_r.cell_position ||
              error_code !== exp_r.error_code || last !== exp_r.last) begin
            if (bad_count < 10)
              $display("mismatch: expected %0d/%h/%0d/%0d/%0d/%b got %0d/%h/%0d/%0d/%0d/%b",
                       exp_r.kind, exp_r.value, exp_r.table_position,
                       exp_r.cell_position, exp_r.error_code, exp_r.last,
                       kind, value, table_position, cell_position, error_code, last);
            bad_count++;
          end
        end
      end
      if (in_valid && in_ready) parse_byte(data_byte);
    end
    mismatches <= bad_count;
    pending <= expected_results.size();
  end

endmodule

FILE: dv/tb_table_database_stream_parser.sv
// testbench top for the table database stream parser
// builds one random file with directed tables up front, drives it with random gaps
// depends on tdsp_pkg, tdsp_checker and the parser rtl
module tb_table_database_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        config_write;
  logic [1:0]  config_index;
  logic [31:0] config_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  kind;
  logic [31:0] value;
  logic [16:0] table_position;
  logic [26:0] cell_position;
  logic [3:0]  error_code;
  logic        last;
  int          mismatches;
  int          pending;

  logic [7:0] payload_bytes[$];
  logic [7:0] file_bytes[$];
  int         burst_left;
  int         stall_left;

  table_database_stream_parser dut (.*);

  tdsp_checker checker_i (.*);

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("FAIL table_database_stream_parser");
    $finish;
  end

  // result side stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 15) stall_left <= $urandom_range(1, 3);
      else if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(20, 60);
    end
  end

  task automatic add_payload(logic [7:0] b);
    payload_bytes.insert(payload_bytes.size(), b);
  endtask

  task automatic add_file(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) add_payload(w[8*i +: 8]);
  endtask

  // one table: header words, numeric cells, then strings
  task automatic put_table(logic [31:0] number, int rows, int cols);
    int len;
    put_word(number);
    put_word(rows);
    put_word(cols);
    for (int i = 0; i < rows * cols; i++) put_word($urandom);
    for (int i = 0; i < rows * cols; i++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      put_word(len);
      for (int j = 0; j < len; j++) add_payload(8'($urandom));
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    config_write <= 1'b1;
    config_index <= idx;
    config_data <= data;
    @(posedge clk);
  endtask

  function automatic int gap_len();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // stimulus
  initial begin
    int tables;
    int variant;
    int stored;
    int flen;
    int tlimit;
    int g;
    int pause_a;
    int pause_b;
    int pause_c;
    rst = 1'b1;
    config_write = 1'b0;
    config_index = tdsp_pkg::REG_FILE_LENGTH;
    config_data = 32'd0;
    in_valid = 1'b0;
    data_byte = 8'd0;
    burst_left = 0;

    // directed tables: extreme words, an empty table, empty and full strings
    put_word(32'hFFFF_FFFF);
    put_word(32'd0);
    put_word(32'd5);
    put_word(32'd0);
    put_word(32'd1);
    put_word(32'd2);
    put_word(32'd0);
    put_word(32'hFFFF_FFFF);
    put_word(32'd0);
    put_word(32'd3);
    add_payload(8'h00);
    add_payload(8'hFF);
    add_payload(8'h5A);
    tables = 2;
    // random tables, with a rare stub of a negative number word and a row word of one
    while (payload_bytes.size() < 1150) begin
      if ($urandom_range(0, 299) == 0) begin
        put_word($urandom | 32'h8000_0000);
        put_word(32'd1);
      end else begin
        put_table($urandom, $urandom_range(0, 3), $urandom_range(0, 3));
      end
      tables++;
    end

    variant = $urandom_range(0, 19);
    stored = payload_bytes.size() + 4;
    if (variant == 15) begin
      // stray bytes inside the payload after the last table
      for (int i = 0; i < 8; i++) add_payload(8'($urandom));
      stored = stored + 8;
    end
    flen = 24 + stored;
    if (variant == 16) stored = stored - $urandom_range(1, 40);
    if (variant == 17) flen = flen - 1;
    if (variant == 18) flen = $urandom_range(0, 23);
    tlimit = ($urandom_range(0, 15) == 0) ? tables - 1 : $urandom_range(tables, 100000);

    // file: magic, header filler, flag, size, count, payload
    for (int i = 0; i < tdsp_pkg::MAGIC_BYTES; i++) add_file(tdsp_pkg::MAGIC_TEXT[i]);
    if (variant == 19) file_bytes[$urandom_range(0, 11)] ^= 8'h01 << $urandom_range(0, 7);
    for (int i = tdsp_pkg::MAGIC_BYTES; i < tdsp_pkg::HEADER_BYTES; i++)
      add_file(8'($urandom));
    g = (variant == 14) ? ($urandom | 32'd1) : 0;
    for (int i = 0; i < 4; i++) add_file(g[8*i +: 8]);
    for (int i = 0; i < 4; i++) add_file(stored[8*i +: 8]);
    for (int i = 0; i < 4; i++) add_file(tables[8*i +: 8]);
    foreach (payload_bytes[i]) add_file(payload_bytes[i]);
    // bytes past the end are dropped
    for (int i = 0; i < 16; i++) add_file(8'($urandom));
    pause_a = 200;
    pause_b = file_bytes.size() / 2;
    pause_c = file_bytes.size() - 160;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_reg(tdsp_pkg::REG_FILE_LENGTH, flen);
    write_reg(tdsp_pkg::REG_MAX_TABLES, tlimit);
    write_reg(tdsp_pkg::REG_MAX_CELLS, $urandom_range(16, 100000000));
    config_write <= 1'b0;
    @(posedge clk);

    foreach (file_bytes[i]) begin
      if (i == pause_a || i == pause_b || i == pause_c) begin
        // drain and let the block settle before touching registers
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (i == pause_a) begin
          write_reg(tdsp_pkg::REG_MAX_CELLS, 32'(tdsp_pkg::MAX_CELL_RESET));
          write_reg(tdsp_pkg::REG_MAX_TABLES, 32'(tdsp_pkg::MAX_TABLE_RESET));
        end else if (i == pause_b) begin
          write_reg(tdsp_pkg::REG_FILE_LENGTH, 32'hFFFF_FFFF);
          write_reg(tdsp_pkg::REG_MAX_CELLS,
                    32'($urandom_range(0, 1) ? 27'd9 : tdsp_pkg::MAX_CELL_RESET));
        end else begin
          write_reg(tdsp_pkg::REG_MAX_CELLS,
                    32'($urandom_range(0, 1) ? 27'd0 : tdsp_pkg::MAX_CELL_RESET));
          write_reg(tdsp_pkg::REG_MAX_TABLES, 32'd0);
        end
        config_write <= 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          in_valid <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      data_byte <= file_bytes[i];
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS table_database_stream_parser");
    end else begin
      $display("FAIL table_database_stream_parser");
    end
    $finish;
  end

endmodule
